>>> src/aqg_pkg.sv
package aqg_pkg;

    // Width of every coordinate, in the configuration and in the step requests.
    localparam int COORD_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_END_X    = 3'd2,
        CFG_END_Y    = 3'd3,
        CFG_CENTER_X = 3'd4,
        CFG_CENTER_Y = 3'd5
    } cfg_index_t;

    // Quadrant code: bit 0 is x at or right of center, bit 1 is y at or below center.
    typedef enum logic [1:0] {
        Q_TL = 2'd0,
        Q_TR = 2'd1,
        Q_BL = 2'd2,
        Q_BR = 2'd3
    } quad_t;

    typedef struct packed {
        logic   first_step;
        coord_t tl_x;
        coord_t tl_y;
        coord_t tr_x;
        coord_t tr_y;
        coord_t bl_x;
        coord_t bl_y;
        coord_t br_x;
        coord_t br_y;
    } step_req_t;

    typedef struct packed {
        logic draw_tl;
        logic draw_tr;
        logic draw_bl;
        logic draw_br;
    } draw_req_t;

    typedef struct packed {
        logic start_enabled;
        logic end_enabled;
        logic start_done;
        logic end_done;
    } arc_flags_t;

endpackage

>>> src/arc_quadrant_gate.sv
// Arc quadrant gate for an ellipse rasterizer.
//
// The step channel (in_valid, in_stall, in_data) takes one request per ellipse
// step carrying the four mirrored points and a first_step bit. The result channel
// (out_valid, out_stall, out_data) returns one request per step with four draw
// flags, in order. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) writes the arc start, end and center registers; cfg_ready is always
// high, and writes are expected only while no step is in flight.
// A step is accepted into an input register, evaluated in one pass of compare
// logic against the configuration and the arc flags, and lands in the result
// register when the evaluation stage moves on. A new step is accepted every cycle,
// limited only by the receiver. When the receiver stalls, the result register
// holds; the input register still takes a request if it is empty, after which
// in_stall rises until the result drains.
// Reset clears both registers' valid bits and the configuration to zero, which
// puts the start and end points in the bottom-right quadrant: the start flag
// comes up disabled and the end flag enabled, both not done.
module arc_quadrant_gate
    import aqg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  step_req_t                  in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output draw_req_t                  out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]     cfg_data
);

    // Configuration registers.
    coord_t start_x_reg, start_y_reg, end_x_reg, end_y_reg, center_x_reg, center_y_reg;

    // Pipeline registers.
    logic       in_valid_reg;
    step_req_t  in_data_reg;
    logic       out_valid_reg;
    draw_req_t  out_data_reg;

    // Arc tracking flags, carried from one step to the next.
    arc_flags_t flags_reg;
    arc_flags_t flags_next;
    arc_flags_t flags_init;

    draw_req_t  draw_next;
    logic       advance;
    logic       in_load;

    quad_t      sq;
    quad_t      eq;
    logic [3:0] full;
    logic       slice;
    logic       wide;
    logic [3:0] draw;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // The evaluation stage moves on whenever the result register is free or drains.
    assign advance   = !out_valid_reg || !out_stall;
    // The input register takes a new request when it is empty or its step moves on.
    assign in_load   = !in_valid_reg || advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_X:  start_x_reg  <= coord_t'(cfg_data);
                CFG_START_Y:  start_y_reg  <= coord_t'(cfg_data);
                CFG_END_X:    end_x_reg    <= coord_t'(cfg_data);
                CFG_END_Y:    end_y_reg    <= coord_t'(cfg_data);
                CFG_CENTER_X: center_x_reg <= coord_t'(cfg_data);
                CFG_CENTER_Y: center_y_reg <= coord_t'(cfg_data);
                default:      ;
            endcase
        end
    end

    // Quadrants of the start and end points follow the configuration directly.
    always_comb
    begin
        sq = quad_t'({start_y_reg >= center_y_reg, start_x_reg >= center_x_reg});
        eq = quad_t'({end_y_reg >= center_y_reg, end_x_reg >= center_x_reg});
    end

    // Quadrants swept whole by the counter-clockwise arc, and the one-quadrant case.
    always_comb
    begin
        full  = 4'b0000;
        slice = 1'b0;
        wide  = 1'b0;
        if (sq != eq)
        begin
            unique case ({sq, eq})
                {Q_TL, Q_TR}: full = 4'b1100;
                {Q_TL, Q_BR}: full = 4'b0100;
                {Q_TR, Q_BL}: full = 4'b0001;
                {Q_TR, Q_BR}: full = 4'b0101;
                {Q_BL, Q_TL}: full = 4'b1010;
                {Q_BL, Q_TR}: full = 4'b1000;
                {Q_BR, Q_TL}: full = 4'b0010;
                {Q_BR, Q_BL}: full = 4'b0011;
                default:      full = 4'b0000;
            endcase
        end
        else if (start_x_reg == end_x_reg && start_y_reg == end_y_reg)
        begin
            full = 4'b1111;
        end
        else
        begin
            // Start and end share a quadrant: the arc either goes almost all the
            // way around, or stays inside that quadrant as a thin slice.
            unique case (sq)
                Q_TL: wide = (start_x_reg < end_x_reg) || (start_y_reg > end_y_reg);
                Q_TR: wide = (start_x_reg < end_x_reg) || (start_y_reg < end_y_reg);
                Q_BL: wide = (start_x_reg > end_x_reg) || (start_y_reg > end_y_reg);
                Q_BR: wide = (start_x_reg > end_x_reg) || (start_y_reg < end_y_reg);
                default: wide = 1'b0;
            endcase
            if (wide)
            begin
                full = 4'b1111;
                full[sq] = 1'b0;
            end
            else
            begin
                slice = 1'b1;
            end
        end
    end

    // Flag update for the step held in the input register.
    always_comb
    begin
        flags_init = flags_reg;
        if (in_data_reg.first_step)
        begin
            flags_init.start_enabled = (sq == Q_TR) || (sq == Q_BL);
            flags_init.end_enabled   = (eq == Q_TL) || (eq == Q_BR);
            flags_init.start_done    = 1'b0;
            flags_init.end_done      = 1'b0;
        end

        flags_next = flags_init;
        if (!flags_init.start_done)
        begin
            if (!flags_init.start_enabled)
            begin
                // The arc enters its start quadrant once the point sweeps past start.
                if ((sq == Q_TL && in_data_reg.tl_x <= start_x_reg
                        && in_data_reg.tl_y >= start_y_reg)
                    || (sq == Q_BR && in_data_reg.br_x >= start_x_reg
                        && in_data_reg.br_y <= start_y_reg))
                begin
                    flags_next.start_enabled = 1'b1;
                    flags_next.start_done    = 1'b1;
                end
            end
            else if ((sq == Q_TR && (in_data_reg.tr_x > start_x_reg
                        || in_data_reg.tr_y > start_y_reg))
                    || (sq == Q_BL && (in_data_reg.bl_x < start_x_reg
                        || in_data_reg.bl_y < start_y_reg)))
            begin
                flags_next.start_enabled = 1'b0;
                flags_next.start_done    = 1'b1;
            end
        end

        if (!flags_init.end_done)
        begin
            if (flags_init.end_enabled)
            begin
                if ((eq == Q_TL && (in_data_reg.tl_x < end_x_reg
                        || in_data_reg.tl_y > end_y_reg))
                    || (eq == Q_BR && (in_data_reg.br_x > end_x_reg
                        || in_data_reg.br_y < end_y_reg)))
                begin
                    flags_next.end_enabled = 1'b0;
                    flags_next.end_done    = 1'b1;
                end
            end
            else if ((eq == Q_TR && in_data_reg.tr_x >= end_x_reg
                        && in_data_reg.tr_y >= end_y_reg)
                    || (eq == Q_BL && in_data_reg.bl_x <= end_x_reg
                        && in_data_reg.bl_y <= end_y_reg))
            begin
                flags_next.end_enabled = 1'b1;
                flags_next.end_done    = 1'b1;
            end
        end
    end

    // Draw flags: whole quadrants, plus the partial start and end quadrants.
    always_comb
    begin
        draw = full;
        if (sq != eq)
        begin
            if (flags_next.start_enabled)
            begin
                draw[sq] = 1'b1;
            end
            if (flags_next.end_enabled)
            begin
                draw[eq] = 1'b1;
            end
        end
        else if (slice)
        begin
            if (flags_next.start_enabled && flags_next.end_enabled)
            begin
                draw[sq] = 1'b1;
            end
        end
        else if (flags_next.start_enabled || flags_next.end_enabled)
        begin
            draw[sq] = 1'b1;
        end

        // When left and right coincide, the right-hand point would be drawn twice.
        if (in_data_reg.tl_x == in_data_reg.tr_x)
        begin
            if (draw[Q_TL] && draw[Q_TR])
            begin
                draw[Q_TR] = 1'b0;
            end
            if (draw[Q_BL] && draw[Q_BR])
            begin
                draw[Q_BR] = 1'b0;
            end
        end

        draw_next.draw_tl = draw[Q_TL];
        draw_next.draw_tr = draw[Q_TR];
        draw_next.draw_bl = draw[Q_BL];
        draw_next.draw_br = draw[Q_BR];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '{start_enabled: 1'b0, end_enabled: 1'b1,
                               start_done: 1'b0, end_done: 1'b0};
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    flags_reg <= flags_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= in_data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= draw_next;
        end
    end

    // The input side stalls only when both registers are full and the receiver waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline had room");

    // A new result appears only when a step sat in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without a step");

    // The arc flags change only when a step moves through evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(flags_reg))
        else $error("arc flags changed without a step");

endmodule
